@@ hdl/skc_pkg.sv @@
// Package for the slow-keys filter: slot, item and result types and all codes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package skc_pkg;

  localparam int unsigned KeySlotsDef = 8;
  localparam int unsigned OutMax      = 8;
  localparam int unsigned ResCntW     = $clog2(OutMax + 1);
  localparam int unsigned DelayW      = 16;
  localparam int unsigned KeyW        = 32;

  localparam logic [DelayW-1:0] DelayReset = 16'd500;

  // Input opcodes.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_OTHER   = 2'd3;

  // Slot status codes; the unused code reads as free.
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_PEND = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  // Result actions.
  localparam logic [1:0] ACT_PASS    = 2'd0;
  localparam logic [1:0] ACT_CONSUME = 2'd1;
  localparam logic [1:0] ACT_DELAYED = 2'd2;

  // Result notices.
  localparam logic [1:0] NTC_NONE     = 2'd0;
  localparam logic [1:0] NTC_KEY_DOWN = 2'd1;
  localparam logic [1:0] NTC_ACCEPTED = 2'd2;
  localparam logic [1:0] NTC_REJECTED = 2'd3;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [DelayW-1:0] count;
    logic [1:0]        status;
  } slot_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [KeyW-1:0] key_code;
  } item_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] out_key;
    logic [1:0]      notice;
    logic            overflow;
    logic            last;
  } result_t;

endpackage

@@ hdl/skc_cell.sv @@
// One slot of the key table: key, countdown and status, in a rotating ring.
// Depends on skc_pkg for the slot type and the status codes.
module skc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_en_i,
  input  skc_pkg::slot_t shift_i,
  input  logic          wr_en_i,
  input  skc_pkg::slot_t wr_i,
  output skc_pkg::slot_t slot_o
);

  logic [skc_pkg::KeyW-1:0]   key_q;
  logic [skc_pkg::DelayW-1:0] count_q;
  logic [1:0]                 status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= skc_pkg::ST_FREE;
    end else if (shift_en_i) begin
      count_q  <= shift_i.count;
      status_q <= shift_i.status;
    end else if (wr_en_i) begin
      count_q  <= wr_i.count;
      status_q <= wr_i.status;
    end
  end

  // The key is only looked at while the slot is in use, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      key_q <= shift_i.key;
    end else if (wr_en_i) begin
      key_q <= wr_i.key;
    end
  end

  assign slot_o = '{key: key_q, count: count_q, status: status_q};

endmodule

@@ hdl/slow_keys_filter_top.sv @@
// Slow-keys filter top level: controller and the ring of key slots.
// Depends on skc_pkg and skc_cell.
//
// A transaction is taken when start is high and busy is low. A press, release
// or tick rotates the slot ring once, one slot per cycle past the head, and
// then passes through a finishing state; busy stays high over the pass and
// the finishing state, and the next transaction can start once busy falls. An
// other event goes straight to the finishing state. Results leave through an
// output register with a one-cycle strobe and cannot be held off, so the final
// result of a transaction shows in the first cycle after busy falls. A tick
// gives up to eight delayed presses as its ring pass finds them, the last one
// in that first cycle after busy falls; a tick with no expiry gives no result.
// The delay register must be written only while busy is low.
module slow_keys_filter_top #(
  parameter int unsigned KEY_SLOTS = skc_pkg::KeySlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  skc_pkg::item_t               item_i,
  input  logic                         cfg_we_i,
  input  logic [skc_pkg::DelayW-1:0]   cfg_wdata_i,
  output logic                         result_valid_o,
  output skc_pkg::result_t             result_o
);

  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned ResW = skc_pkg::ResCntW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [IdxW-1:0]            cnt_q, cnt_d;
  logic [1:0]                 op_q, op_d;
  logic [skc_pkg::KeyW-1:0]   key_q, key_d;
  logic                       match_found_q, match_found_d;
  logic [IdxW-1:0]            match_idx_q, match_idx_d;
  logic                       match_pend_q, match_pend_d;
  logic                       free_found_q, free_found_d;
  logic [IdxW-1:0]            free_idx_q, free_idx_d;
  logic [ResW-1:0]            exp_cnt_q, exp_cnt_d;
  logic                       hold_valid_q, hold_valid_d;
  logic [skc_pkg::KeyW-1:0]   hold_key_q, hold_key_d;
  logic                       res_valid_q, res_valid_d;
  skc_pkg::result_t           res_q, res_d;
  logic [skc_pkg::DelayW-1:0] delay_q;

  skc_pkg::slot_t             slot_q [KEY_SLOTS];
  skc_pkg::slot_t             head, tail_in, wr_data;
  logic                       shift_en;
  logic                       wr_valid;
  logic [IdxW-1:0]            wr_idx;
  logic [KEY_SLOTS-1:0]       wr_en;
  logic                       head_pend, head_use, expire;
  logic [skc_pkg::DelayW-1:0] dec_cnt;

  // Ring of slots: cell 0 is the head, the tail takes the modified head.
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    skc_pkg::slot_t shift_in;
    if (i == KEY_SLOTS - 1) begin : g_tail
      assign shift_in = tail_in;
    end else begin : g_mid
      assign shift_in = slot_q[i+1];
    end
    assign wr_en[i] = wr_valid && (wr_idx == IdxW'(i));
    skc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .shift_i    (shift_in),
      .wr_en_i    (wr_en[i]),
      .wr_i       (wr_data),
      .slot_o     (slot_q[i])
    );
  end

  assign head      = slot_q[0];
  assign head_pend = (head.status == skc_pkg::ST_PEND);
  assign head_use  = head_pend || (head.status == skc_pkg::ST_ACC);
  assign dec_cnt   = (head.count != '0) ? head.count - 16'd1 : head.count;
  assign expire    = (op_q == skc_pkg::OP_TICK) && head_pend && (dec_cnt == '0) &&
                     (exp_cnt_q < ResW'(skc_pkg::OutMax));
  assign shift_en  = (state_q == S_SCAN);
  assign busy      = (state_q != S_IDLE);

  always_comb begin
    tail_in = head;
    if ((op_q == skc_pkg::OP_TICK) && head_pend) begin
      tail_in.count = dec_cnt;
      if (expire) begin
        tail_in.status = skc_pkg::ST_ACC;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    op_d          = op_q;
    key_d         = key_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_pend_d  = match_pend_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    exp_cnt_d     = exp_cnt_q;
    hold_valid_d  = hold_valid_q;
    hold_key_d    = hold_key_q;
    res_valid_d   = 1'b0;
    res_d         = '0;
    wr_valid      = 1'b0;
    wr_idx        = '0;
    wr_data       = '{key: key_q, count: '0, status: skc_pkg::ST_FREE};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d          = item_i.opcode;
          key_d         = item_i.key_code;
          cnt_d         = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          exp_cnt_d     = '0;
          hold_valid_d  = 1'b0;
          state_d       = (item_i.opcode == skc_pkg::OP_OTHER) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (head_use && (head.key == key_q) && !match_found_q) begin
          match_found_d = 1'b1;
          match_idx_d   = cnt_q;
          match_pend_d  = head_pend;
        end
        if (!head_use && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cnt_q;
        end
        // Each expiry is held back one step so the final one can carry last.
        if (expire) begin
          exp_cnt_d    = exp_cnt_q + ResW'(1);
          hold_valid_d = 1'b1;
          hold_key_d   = head.key;
          if (hold_valid_q) begin
            res_valid_d = 1'b1;
            res_d       = '{action: skc_pkg::ACT_DELAYED, out_key: hold_key_q,
                            notice: skc_pkg::NTC_ACCEPTED, overflow: 1'b0, last: 1'b0};
          end
        end
        if (cnt_q == IdxW'(KEY_SLOTS - 1)) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
        case (op_q)
          skc_pkg::OP_TICK: begin
            if (hold_valid_q) begin
              res_valid_d = 1'b1;
              res_d       = '{action: skc_pkg::ACT_DELAYED, out_key: hold_key_q,
                              notice: skc_pkg::NTC_ACCEPTED, overflow: 1'b0, last: 1'b1};
            end
          end
          skc_pkg::OP_PRESS: begin
            res_valid_d = 1'b1;
            wr_data     = '{key: key_q, count: delay_q, status: skc_pkg::ST_PEND};
            if (match_found_q || free_found_q) begin
              wr_valid = 1'b1;
              wr_idx   = match_found_q ? match_idx_q : free_idx_q;
              res_d    = '{action: skc_pkg::ACT_CONSUME, out_key: key_q,
                           notice: skc_pkg::NTC_KEY_DOWN, overflow: 1'b0, last: 1'b1};
            end else begin
              res_d    = '{action: skc_pkg::ACT_PASS, out_key: key_q,
                           notice: skc_pkg::NTC_NONE, overflow: 1'b1, last: 1'b1};
            end
          end
          skc_pkg::OP_RELEASE: begin
            res_valid_d = 1'b1;
            wr_valid    = match_found_q;
            wr_idx      = match_idx_q;
            if (match_found_q && match_pend_q) begin
              res_d = '{action: skc_pkg::ACT_CONSUME, out_key: key_q,
                        notice: skc_pkg::NTC_REJECTED, overflow: 1'b0, last: 1'b1};
            end else begin
              res_d = '{action: skc_pkg::ACT_PASS, out_key: key_q,
                        notice: skc_pkg::NTC_NONE, overflow: 1'b0, last: 1'b1};
            end
          end
          default: begin
            res_valid_d = 1'b1;
            res_d       = '{action: skc_pkg::ACT_PASS, out_key: '0,
                            notice: skc_pkg::NTC_NONE, overflow: 1'b0, last: 1'b1};
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      exp_cnt_q     <= '0;
      hold_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
      delay_q       <= skc_pkg::DelayReset;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      exp_cnt_q     <= exp_cnt_d;
      hold_valid_q  <= hold_valid_d;
      res_valid_q   <= res_valid_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    match_idx_q  <= match_idx_d;
    match_pend_q <= match_pend_d;
    free_idx_q   <= free_idx_d;
    hold_key_q   <= hold_key_d;
    res_q        <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ hdl/skc_checker.sv @@
// Port-level checker for the slow-keys filter, bound to the top level.
// Depends on skc_pkg for the result type and codes.
module skc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input skc_pkg::result_t result_o
);

  // A taken transaction keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a start");

  // No result can show up right after a new transaction is taken.
  a_quiet_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result strobe right after a start");

  a_overflow_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.overflow |->
      (result_o.action == skc_pkg::ACT_PASS) && (result_o.notice == skc_pkg::NTC_NONE))
    else $error("overflow on a result that is not a plain pass");

  a_delayed_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.action == skc_pkg::ACT_DELAYED) |->
      (result_o.notice == skc_pkg::NTC_ACCEPTED) && !result_o.overflow)
    else $error("delayed press without an accepted notice");

endmodule

bind slow_keys_filter_top skc_checker u_skc_checker (.*);
